// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL in this folder.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("property violated");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- rtl/core/psbsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psbsc_pkg;

    // Configuration register widths
    localparam int CFG_SIZE_W = 11;
    localparam int THR_W      = 8;

    // Result width and saturation value
    localparam int COUNT_W = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register file port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Reset values of the configuration registers
    localparam logic [CFG_SIZE_W-1:0] ROWS_RESET = CFG_SIZE_W'(6);
    localparam logic [CFG_SIZE_W-1:0] COLS_RESET = CFG_SIZE_W'(8);
    localparam logic [THR_W-1:0]      THR_RESET  = THR_W'(6);

    // Register index, taken from paddr word address
    typedef enum logic [1:0] {
        REG_FRAME_ROWS = 2'd0,
        REG_FRAME_COLS = 2'd1,
        REG_THRESHOLD  = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/core/plus_stencil_bright_spot_counter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Plus-shaped five-point stencil bright-spot counter.
// Pixels enter on the s_ stream in raster order, one transfer per pixel;
// frame size and brightness threshold come from the APB registers
// (frame_rows at 0x0, frame_cols at 0x4, brightness_threshold at 0x8).
// Each interior pixel whose sum with its four direct neighbors exceeds
// 5 * threshold bumps a counter. After the last pixel of the frame, one
// transfer on the m_ stream carries the count and the counter restarts.
// Throughput: one pixel per cycle. The stencil for the pixel above the
// arriving one is formed in the stage after the input transfer, from two
// simple dual-port line buffers that are read while the pixel is accepted.
// The count enters the m_ output register as the last pixel leaves the
// stencil stage. The m_ output is a register, so the next frame streams in
// while a count waits. Only when a second count is ready while the first is
// still unread does s_tready drop, until m_tready takes the first.
// Reset returns the registers to 6 rows, 8 columns, threshold 6, clears
// the position and count; line buffer contents are not cleared, and stale
// entries are read only for pixels that are not counted.
module plus_stencil_bright_spot_counter
    import psbsc_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int PIXEL_BITS = 8,
    localparam int S_DW      = ((PIXEL_BITS + 7) / 8) * 8,
    localparam int M_DW      = ((COUNT_W + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [S_DW-1:0]   s_tdata,    // [PIXEL_BITS-1:0] pixel

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [M_DW-1:0]        m_tdata,    // [COUNT_W-1:0] spot_count

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int SCW  = ($clog2(MAX_COLS + 1) > CFG_SIZE_W) ?
                          $clog2(MAX_COLS + 1) : CFG_SIZE_W;
    localparam int SRW  = ($clog2(MAX_ROWS + 1) > CFG_SIZE_W) ?
                          $clog2(MAX_ROWS + 1) : CFG_SIZE_W;
    localparam int SUM_W = ((PIXEL_BITS + 3) > (THR_W + 3)) ? (PIXEL_BITS + 3) : (THR_W + 3);

    // Configuration registers
    logic [CFG_SIZE_W-1:0] rows_cfg_reg;
    logic [CFG_SIZE_W-1:0] cols_cfg_reg;
    logic [THR_W-1:0]      thr_reg;

    // Raster position and frame count
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               same_col_reg;

    // Stencil stage
    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic                  s1_interior_reg;
    logic                  s1_fwd_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [PIXEL_BITS-1:0] recent_rd_reg;
    logic [PIXEL_BITS-1:0] older_rd_reg;
    logic [PIXEL_BITS-1:0] centre_reg;
    logic [PIXEL_BITS-1:0] left_reg;
    logic [PIXEL_BITS-1:0] prev_px_reg;

    // Result register
    logic               m_tvalid_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // Line buffers
    logic [PIXEL_BITS-1:0] recent_mem [MAX_COLS];
    logic [PIXEL_BITS-1:0] older_mem  [MAX_COLS];

    logic            cfg_wr;
    cfg_reg_t        cfg_idx;
    logic [SRW-1:0]  rows_ext;
    logic [SRW-1:0]  rows_eff;
    logic [SCW-1:0]  cols_ext;
    logic [SCW-1:0]  cols_eff;
    logic [SCW-1:0]  c_ext;
    logic [SCW-1:0]  c_inc;
    logic [SRW-1:0]  r_ext;
    logic [SRW-1:0]  r_inc;
    logic            row_end;
    logic            frame_end;
    logic            interior;
    logic [CW-1:0]   col_next;
    logic [RW-1:0]   row_next;
    logic            in_fire;
    logic            out_free;
    logic            s1_stall;
    logic            s1_fire;
    logic [PIXEL_BITS-1:0] centre_eff;
    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      thr5;
    logic                  hit;
    logic [COUNT_W-1:0]    count_inc;

    // Register port decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_reg_t'(paddr[3:2]);

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_FRAME_ROWS: prdata = APB_DW'(rows_cfg_reg);
            REG_FRAME_COLS: prdata = APB_DW'(cols_cfg_reg);
            REG_THRESHOLD:  prdata = APB_DW'(thr_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamp frame size to 1..MAX
    always_comb begin
        rows_ext = SRW'(rows_cfg_reg);
        cols_ext = SCW'(cols_cfg_reg);
        if (rows_ext == '0) begin
            rows_eff = SRW'(1);
        end else if (rows_ext > SRW'(MAX_ROWS)) begin
            rows_eff = SRW'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        if (cols_ext == '0) begin
            cols_eff = SCW'(1);
        end else if (cols_ext > SCW'(MAX_COLS)) begin
            cols_eff = SCW'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
    end

    // Position bookkeeping for the arriving pixel
    always_comb begin
        c_ext     = SCW'(col_reg);
        c_inc     = c_ext + SCW'(1);
        r_ext     = SRW'(row_reg);
        r_inc     = r_ext + SRW'(1);
        row_end   = (c_inc >= cols_eff);
        frame_end = row_end && !(r_inc < rows_eff);
        interior  = (r_ext >= SRW'(2)) && (r_ext < rows_eff) &&
                    (c_ext >= SCW'(1)) && (c_inc < cols_eff);
        col_next  = row_end ? '0 : c_inc[CW-1:0];
        if (!row_end) begin
            row_next = row_reg;
        end else if (frame_end) begin
            row_next = '0;
        end else begin
            row_next = r_inc[RW-1:0];
        end
    end

    // Handshake: stall input only when a finished count cannot move out
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_stall = s1_valid_reg && s1_last_reg && !out_free;
    assign s1_fire  = s1_valid_reg && !s1_stall;
    assign s_tready = !s1_stall;
    assign in_fire  = s_tvalid && s_tready;

    // Stencil sum and threshold test
    assign centre_eff = s1_fwd_reg ? prev_px_reg : centre_reg;
    assign sum  = SUM_W'(s1_px_reg) + SUM_W'(older_rd_reg) + SUM_W'(centre_eff)
                + SUM_W'(left_reg) + SUM_W'(recent_rd_reg);
    assign thr5 = (SUM_W'(thr_reg) << 2) + SUM_W'(thr_reg);
    assign hit  = s1_interior_reg && (sum > thr5) && (count_reg != COUNT_MAX);
    assign count_inc = count_reg + COUNT_W'(hit);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLS_RESET;
            thr_reg      <= THR_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            count_reg    <= '0;
            same_col_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Register writes
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_FRAME_ROWS: rows_cfg_reg <= pwdata[CFG_SIZE_W-1:0];
                    REG_FRAME_COLS: cols_cfg_reg <= pwdata[CFG_SIZE_W-1:0];
                    REG_THRESHOLD:  thr_reg      <= pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
            // Advance raster position
            if (in_fire) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                same_col_reg <= (col_next == col_reg);
            end
            // Stage valid
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            // Count and clear at frame end
            if (s1_fire) begin
                count_reg <= s1_last_reg ? '0 : count_inc;
            end
            // Result valid
            if (s1_fire && s1_last_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Stencil stage payload; read line buffers with write bypass
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_last_reg     <= frame_end;
            s1_interior_reg <= interior;
            s1_fwd_reg      <= same_col_reg;
            s1_col_reg      <= col_reg;
            s1_px_reg       <= s_tdata[PIXEL_BITS-1:0];
            centre_reg      <= recent_rd_reg;
            recent_rd_reg   <= (s1_fire && (s1_col_reg == col_next)) ?
                               s1_px_reg : recent_mem[col_next];
            older_rd_reg    <= (s1_fire && (s1_col_reg == col_reg)) ?
                               centre_eff : older_mem[col_reg];
        end
        if (s1_fire) begin
            left_reg    <= centre_eff;
            prev_px_reg <= s1_px_reg;
        end
        if (s1_fire && s1_last_reg) begin
            out_count_reg <= count_inc;
        end
    end

    // Shift the column of each stencil pixel into the line buffers
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            recent_mem[s1_col_reg] <= s1_px_reg;
            older_mem[s1_col_reg]  <= centre_eff;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DW'(out_count_reg);

`include "assert_macros.svh"

    `ASSERT_PROP(a_count_clears, aclk, aresetn, (s1_fire && s1_last_reg) |=> (count_reg == '0))
    `ASSERT_PROP(a_result_loads, aclk, aresetn, (s1_fire && s1_last_reg) |=> m_tvalid)
    `ASSERT_PROP(a_count_step, aclk, aresetn, (s1_fire && !s1_last_reg) |=> ((count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + COUNT_W'(1))))
    `ASSERT_PROP(a_stage_holds, aclk, aresetn, s1_stall |=> (s1_valid_reg && s1_last_reg))
    `ASSERT_NEVER(a_no_accept_on_full, aclk, aresetn, in_fire && s1_valid_reg && s1_last_reg && m_tvalid_reg && !m_tready)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import psbsc_pkg::*;

    localparam int MAX_COLS       = 1024;
    localparam int MAX_ROWS       = 1024;
    localparam int PIXEL_BITS     = 8;
    localparam int S_DW           = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int M_DW           = ((COUNT_W + 7) / 8) * 8;
    localparam int STENCIL_POINTS = 5;
    localparam int SETTLE_CYCLES  = 6;
    localparam int STALL_LIMIT    = 5000;
    localparam int LONG_HOLD      = 400;

    typedef enum int {
        FILL_UNIFORM,
        FILL_NEAR_THRESHOLD,
        FILL_SPARSE,
        FILL_CONST
    } fill_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DW-1:0]        s_tdata  = '0;   // [7:0] pixel
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DW-1:0]        m_tdata;         // [19:0] spot_count
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_AW-1:0]      paddr    = '0;
    logic [APB_DW-1:0]      pwdata   = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // Shadow of the block: registers, line buffers, raster position, count
    logic [CFG_SIZE_W-1:0]  cfg_rows = ROWS_RESET;
    logic [CFG_SIZE_W-1:0]  cfg_cols = COLS_RESET;
    logic [THR_W-1:0]       cfg_thr  = THR_RESET;
    bit   [PIXEL_BITS-1:0]  recent_row [MAX_COLS];
    bit   [PIXEL_BITS-1:0]  older_row  [MAX_COLS];
    bit   [PIXEL_BITS-1:0]  left_px    = '0;
    bit   [PIXEL_BITS-1:0]  centre_px  = '0;
    int unsigned            pos_row    = 0;
    int unsigned            pos_col    = 0;
    bit   [COUNT_W-1:0]     bright_count = '0;
    logic [COUNT_W-1:0]     expected_counts [$];

    int                     errors        = 0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int unsigned            hold_done     = 0;
    int unsigned            hold_until    = 0;
    int unsigned            quiet_cycles  = 0;

    plus_stencil_bright_spot_counter #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .PIXEL_BITS (PIXEL_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Zero acts as one, oversize acts as the maximum
    function automatic int unsigned frame_extent(input logic [CFG_SIZE_W-1:0] v,
                                                 input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // Advance the shadow by one pixel; queue the count at frame end
    function automatic void predict_bright_count(input logic [PIXEL_BITS-1:0] px);
        int unsigned rows;
        int unsigned cols;
        int unsigned above;
        int unsigned right;
        int unsigned sum;
        rows      = frame_extent(cfg_rows, MAX_ROWS);
        cols      = frame_extent(cfg_cols, MAX_COLS);
        centre_px = recent_row[pos_col];
        above     = older_row[pos_col];
        right     = (pos_col + 1 < MAX_COLS) ? recent_row[pos_col + 1] : 0;
        if (pos_row >= 2 && pos_row < rows && pos_col >= 1 && pos_col + 1 < cols) begin
            sum = px + above + centre_px + left_px + right;
            if (sum > STENCIL_POINTS * cfg_thr && bright_count != COUNT_MAX)
                bright_count++;
        end
        older_row[pos_col]  = centre_px;
        recent_row[pos_col] = px;
        left_px             = centre_px;
        if (pos_col + 1 < cols) begin
            pos_col++;
        end else begin
            pos_col = 0;
            if (pos_row + 1 < rows) begin
                pos_row++;
            end else begin
                expected_counts.push_back(bright_count);
                left_px      = '0;
                centre_px    = '0;
                pos_row      = 0;
                bright_count = '0;
            end
        end
    endfunction

    // Track register writes and accepted pixels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (cfg_reg_t'(paddr[3:2]))
                    REG_FRAME_ROWS: cfg_rows = pwdata[CFG_SIZE_W-1:0];
                    REG_FRAME_COLS: cfg_cols = pwdata[CFG_SIZE_W-1:0];
                    REG_THRESHOLD:  cfg_thr  = pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_bright_count(s_tdata[PIXEL_BITS-1:0]);
        end
    end

    // Compare each count transfer with the oldest prediction
    always @(posedge aclk) begin
        logic [COUNT_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_counts.size() == 0) begin
                errors++;
                $display("%0t: spot count mismatch, expected none, actual %0d",
                         $time, m_tdata);
            end else begin
                want = expected_counts.pop_front();
                if (m_tdata !== M_DW'(want)) begin
                    errors++;
                    $display("%0t: spot count mismatch, expected %0d, actual %0d",
                             $time, want, m_tdata);
                end
            end
        end
    end

    // Stall the result side at random, or for a requested long stretch
    always @(posedge aclk) begin
        if (hold_done < hold_until) begin
            m_tready <= 1'b0;
            hold_done++;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // End the run when nothing has moved for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(input int unsigned rows, input int unsigned cols,
                             input int unsigned thr);
        write_reg(REG_FRAME_ROWS, APB_DW'(rows));
        write_reg(REG_FRAME_COLS, APB_DW'(cols));
        write_reg(REG_THRESHOLD,  APB_DW'(thr));
    endtask

    // Drop valid and hold until every count has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_counts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] px);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DW'(px);
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Stream one whole frame at the current register setting
    task automatic send_frame(input fill_t mode, input logic [PIXEL_BITS-1:0] level);
        int unsigned total;
        int          v;
        total = frame_extent(cfg_rows, MAX_ROWS) * frame_extent(cfg_cols, MAX_COLS);
        repeat (total) begin
            case (mode)
                FILL_UNIFORM:        v = $urandom_range(255);
                FILL_NEAR_THRESHOLD: v = int'(cfg_thr) + int'($urandom_range(6)) - 3;
                FILL_SPARSE:         v = ($urandom_range(9) == 0) ? 255 : $urandom_range(3);
                default:             v = level;
            endcase
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            send_pixel(PIXEL_BITS'(v));
        end
    endtask

    task automatic test_default_registers();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        send_frame(FILL_UNIFORM, '0);
        send_frame(FILL_NEAR_THRESHOLD, '0);
        wait_drained();
    endtask

    task automatic test_threshold_boundary();
        set_frame(5, 5, 0);
        send_frame(FILL_CONST, 8'd0);
        send_frame(FILL_CONST, 8'd1);
        wait_drained();
        write_reg(REG_THRESHOLD, APB_DW'(255));
        send_frame(FILL_CONST, 8'd255);
        wait_drained();
        write_reg(REG_THRESHOLD, APB_DW'(254));
        send_frame(FILL_CONST, 8'd255);
        wait_drained();
        // Sum equal to five times the threshold must not count; one more must
        write_reg(REG_THRESHOLD, APB_DW'(100));
        for (int i = 0; i < 25; i++)
            send_pixel((i == 12) ? 8'd101 : 8'd100);
        wait_drained();
    endtask

    task automatic test_frame_size_extremes();
        int unsigned size_rows [10] = '{0, 1, 1, 7, 2, 9, 3, 3, 4, 0};
        int unsigned size_cols [10] = '{0, 1, 7, 1, 9, 2, 3, 10, 3, 5};
        for (int i = 0; i < 10; i++) begin
            set_frame(size_rows[i], size_cols[i], $urandom_range(255));
            send_frame(fill_t'(i % 3), '0);
            wait_drained();
        end
    endtask

    task automatic random_phase(input int s_pct, input int r_pct);
        int unsigned sent;
        int unsigned frames;
        int unsigned rows;
        int unsigned cols;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent   = 0;
        frames = 0;
        while (sent < 70 || frames < 3) begin
            // Change the setting between frames about half the time
            if (frames == 0 || $urandom_range(1) == 1) begin
                wait_drained();
                rows = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(6);
                cols = ($urandom_range(9) == 0) ? $urandom_range(16) : $urandom_range(8);
                set_frame(rows, cols, $urandom_range(255));
            end
            send_frame(fill_t'($urandom_range(2)), '0);
            sent += frame_extent(cfg_rows, MAX_ROWS) * frame_extent(cfg_cols, MAX_COLS);
            frames++;
        end
        wait_drained();
    endtask

    task automatic test_random_frames();
        random_phase(24, 70);
        random_phase(70, 24);
        random_phase(0, 0);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_frame(3, 3, $urandom_range(255));
        // Block the result side while frames keep coming, so the input stalls
        hold_until = hold_done + LONG_HOLD;
        repeat (5) send_frame(FILL_UNIFORM, '0);
        wait_drained();
        send_frame(FILL_NEAR_THRESHOLD, '0);
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_registers();
        test_threshold_boundary();
        test_frame_size_extremes();
        test_random_frames();
        test_output_backpressure();
        wait_drained();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/psbsc_pkg.sv
rtl/core/plus_stencil_bright_spot_counter.sv
tb/testbench.sv
